@@ sv/bpq_pkg.sv @@
// Shared constants and types of the bucket priority queue.
package bpq_pkg;

    localparam int NODE_COUNT   = 1024;
    localparam int BUCKET_COUNT = 256;
    localparam int NODE_W       = $clog2(NODE_COUNT);
    localparam int BKT_W        = $clog2(BUCKET_COUNT);
    localparam int LINK_W       = $clog2(NODE_COUNT + 1);
    localparam int CNT_W        = $clog2(NODE_COUNT + 1);
    localparam int SWEEP_LEN    = (NODE_COUNT > BUCKET_COUNT) ? NODE_COUNT : BUCKET_COUNT;
    localparam int SW_W         = $clog2(SWEEP_LEN);
    localparam int MODE_W       = 3;
    localparam int ID_W         = 10;
    localparam int WT_W         = 8;
    localparam int VS_W         = 2;
    localparam int IN_TDATA_W   = 32;
    localparam int OUT_TDATA_W  = 32;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(NODE_COUNT);

    typedef enum logic [MODE_W-1:0] {
        M_INSERT, M_POP, M_UNLINK, M_UPDATE, M_SET, M_FINISH, M_RESET, M_CLRMIN
    } t_mode;

    typedef enum logic [VS_W-1:0] {
        VS_NOT_VISITED, VS_INSERTED, VS_UPDATED, VS_REMOVED
    } t_vstate;

    typedef enum logic [3:0] {
        S_SWEEP, S_IDLE, S_UL_RD, S_UL_CHK, S_INS_RD, S_INS_WR1, S_INS_WR2, S_SET,
        S_POP_RD, S_POP_CHK, S_POP_NX, S_POP_WR, S_DONE
    } t_fsm;

endpackage

@@ sv/bpq_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
module bpq_ram #(
    parameter int W = 8,
    parameter int D = 256
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ sv/bucket_priority_queue_core.sv @@
// Top level of the bucket priority queue: control sequencer and state memories.
//  channel | direction | handshake                | payload
//  s       | in        | i_s_tvalid / o_s_tready  | i_s_tdata: operation
//  m       | out       | o_m_tvalid / i_m_tready  | o_m_tdata: result
// One operation at a time. A pop scans the buckets upward from the minimum until it finds a
// non-empty one, and a pop on an empty queue goes straight to the result with the error flag set.
// Reset states sweeps the state memory one entry per cycle.
// After reset a clearing pass over the state, head and tail memories runs before the first transaction.
// A result waiting on the output does not stop the next transaction being taken.
module bucket_priority_queue_core
    import bpq_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    // mode[2:0], node_id[12:3], bucket_weight[20:13], new_weight[28:21], state_value[30:29]
    input  logic [IN_TDATA_W-1:0]  i_s_tdata,
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    // popped_node[9:0], node_state[11:10], element_count[22:12], is_empty[23], error_flag[24]
    output logic [OUT_TDATA_W-1:0] o_m_tdata
);
    t_fsm r_st, n_st;
    t_mode r_mode;
    logic [NODE_W-1:0] r_node, r_h, r_pop;
    logic [BKT_W-1:0] r_bw, r_nw, r_min, r_b, ib;
    logic [VS_W-1:0] r_sv;
    t_vstate r_nst, r_o_nst;
    logic [CNT_W-1:0] r_count, r_o_count;
    logic [SW_W-1:0] r_sw;
    logic r_init, r_err, r_ov, r_o_err;
    logic [NODE_W-1:0] r_o_pop;

    logic accept, load, do_ul, ul_state, found;
    t_vstate ins_state;

    logic prev_we, next_we, vst_we, head_we, tail_we;
    logic [NODE_W-1:0] prev_waddr, next_waddr, vst_waddr, prev_raddr, next_raddr, vst_raddr;
    logic [LINK_W-1:0] prev_wdata, next_wdata, head_wdata, tail_wdata;
    logic [LINK_W-1:0] prev_rdata, next_rdata, head_rdata, tail_rdata;
    logic [VS_W-1:0] vst_wdata, vst_rdata;
    logic [BKT_W-1:0] head_waddr, tail_waddr, head_raddr, tail_raddr;

    bpq_ram #(.W(LINK_W), .D(NODE_COUNT)) u_prev (
        .i_clk(i_clk), .i_we(prev_we), .i_waddr(prev_waddr), .i_wdata(prev_wdata),
        .i_raddr(prev_raddr), .o_rdata(prev_rdata)
    );
    bpq_ram #(.W(LINK_W), .D(NODE_COUNT)) u_next (
        .i_clk(i_clk), .i_we(next_we), .i_waddr(next_waddr), .i_wdata(next_wdata),
        .i_raddr(next_raddr), .o_rdata(next_rdata)
    );
    bpq_ram #(.W(VS_W), .D(NODE_COUNT)) u_vst (
        .i_clk(i_clk), .i_we(vst_we), .i_waddr(vst_waddr), .i_wdata(vst_wdata),
        .i_raddr(vst_raddr), .o_rdata(vst_rdata)
    );
    bpq_ram #(.W(LINK_W), .D(BUCKET_COUNT)) u_head (
        .i_clk(i_clk), .i_we(head_we), .i_waddr(head_waddr), .i_wdata(head_wdata),
        .i_raddr(head_raddr), .o_rdata(head_rdata)
    );
    bpq_ram #(.W(LINK_W), .D(BUCKET_COUNT)) u_tail (
        .i_clk(i_clk), .i_we(tail_we), .i_waddr(tail_waddr), .i_wdata(tail_wdata),
        .i_raddr(tail_raddr), .o_rdata(tail_rdata)
    );

    assign ib        = (r_mode == M_UPDATE) ? r_nw : r_bw;
    assign ul_state  = (vst_rdata == VS_INSERTED) || (vst_rdata == VS_UPDATED);
    assign do_ul     = (r_mode == M_UNLINK) || ((r_mode == M_UPDATE) && ul_state);
    assign found     = head_rdata < NIL;
    assign ins_state = (r_mode == M_UPDATE) ? VS_UPDATED : VS_INSERTED;
    assign accept    = i_s_tvalid && o_s_tready;

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            S_SWEEP: begin
                if (r_sw == SW_W'(SWEEP_LEN - 1)) begin
                    n_st = r_init ? S_IDLE : S_DONE;
                end
            end
            S_IDLE: begin
                if (i_s_tvalid) begin
                    unique case (t_mode'(i_s_tdata[2:0]))
                        M_INSERT: n_st = S_INS_RD;
                        M_POP: n_st = (r_count == '0) ? S_DONE : S_POP_RD;
                        M_UNLINK, M_UPDATE, M_CLRMIN: n_st = S_UL_RD;
                        M_SET, M_FINISH: n_st = S_SET;
                        M_RESET: n_st = S_SWEEP;
                    endcase
                end
            end
            S_UL_RD: n_st = S_UL_CHK;
            S_UL_CHK: n_st = (r_mode == M_UPDATE) ? S_INS_RD : S_DONE;
            S_INS_RD: n_st = S_INS_WR1;
            S_INS_WR1: n_st = S_INS_WR2;
            S_INS_WR2: n_st = S_DONE;
            S_SET: n_st = S_DONE;
            S_POP_RD: n_st = S_POP_CHK;
            S_POP_CHK: begin
                if (found) begin
                    n_st = S_POP_NX;
                end else if (r_b == BKT_W'(BUCKET_COUNT - 1)) begin
                    n_st = S_DONE;
                end
            end
            S_POP_NX: n_st = S_POP_WR;
            S_POP_WR: n_st = S_DONE;
            S_DONE: begin
                if (!r_ov || i_m_tready) begin
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_tready = (r_st == S_IDLE);
        load       = (r_st == S_DONE) && (!r_ov || i_m_tready);
        prev_we = 1'b0; prev_waddr = r_node; prev_wdata = NIL; prev_raddr = r_node;
        next_we = 1'b0; next_waddr = r_node; next_wdata = NIL; next_raddr = r_node;
        vst_we = 1'b0; vst_waddr = r_node; vst_wdata = ins_state; vst_raddr = r_node;
        head_we = 1'b0; head_waddr = ib; head_wdata = LINK_W'(r_node); head_raddr = ib;
        tail_we = 1'b0; tail_waddr = ib; tail_wdata = LINK_W'(r_node); tail_raddr = ib;
        unique case (r_st)
            S_SWEEP: begin
                vst_we     = ({1'b0, r_sw} < (SW_W + 1)'(NODE_COUNT));
                vst_waddr  = NODE_W'(r_sw);
                vst_wdata  = VS_NOT_VISITED;
                head_we    = r_init && (r_sw < SW_W'(BUCKET_COUNT));
                tail_we    = head_we;
                head_waddr = BKT_W'(r_sw);
                tail_waddr = BKT_W'(r_sw);
                head_wdata = NIL;
                tail_wdata = NIL;
            end
            S_UL_CHK: begin
                if (do_ul) begin
                    if (prev_rdata >= NIL) begin
                        head_we    = 1'b1;
                        head_waddr = r_bw;
                        head_wdata = next_rdata;
                    end else begin
                        next_we    = 1'b1;
                        next_waddr = NODE_W'(prev_rdata);
                        next_wdata = next_rdata;
                    end
                    if (next_rdata >= NIL) begin
                        tail_we    = 1'b1;
                        tail_waddr = r_bw;
                        tail_wdata = prev_rdata;
                    end else begin
                        prev_we    = 1'b1;
                        prev_waddr = NODE_W'(next_rdata);
                        prev_wdata = prev_rdata;
                    end
                end
            end
            S_INS_WR1: begin
                head_we = 1'b1;
                tail_we = 1'b1;
                prev_we = 1'b1;
                vst_we  = 1'b1;
                if (head_rdata >= NIL) begin
                    prev_wdata = NIL;
                    head_wdata = LINK_W'(r_node);
                end else begin
                    prev_wdata = tail_rdata;
                    head_wdata = head_rdata;
                    if (tail_rdata < NIL) begin
                        next_we    = 1'b1;
                        next_waddr = NODE_W'(tail_rdata);
                        next_wdata = LINK_W'(r_node);
                    end
                end
            end
            S_INS_WR2: begin
                next_we    = 1'b1;
                next_wdata = NIL;
            end
            S_SET: begin
                vst_we    = 1'b1;
                vst_wdata = (r_mode == M_SET) ? r_sv : VS_REMOVED;
            end
            S_POP_RD: begin
                head_raddr = r_b;
            end
            S_POP_CHK: begin
                head_raddr = r_b + BKT_W'(1);
            end
            S_POP_NX: begin
                next_raddr = r_h;
                vst_raddr  = r_h;
            end
            S_POP_WR: begin
                head_we    = 1'b1;
                head_waddr = r_b;
                head_wdata = next_rdata;
                tail_waddr = r_b;
                tail_wdata = NIL;
                prev_waddr = NODE_W'(next_rdata);
                prev_wdata = NIL;
                if (next_rdata >= NIL) begin
                    tail_we = 1'b1;
                end else begin
                    prev_we = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_SWEEP;
            r_sw    <= '0;
            r_init  <= 1'b1;
            r_count <= '0;
            r_min   <= '0;
            r_ov    <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ov <= load || (r_ov && !i_m_tready);
            unique case (r_st)
                S_SWEEP: begin
                    r_sw <= r_sw + SW_W'(1);
                    if (r_sw == SW_W'(SWEEP_LEN - 1)) begin
                        r_init <= 1'b0;
                    end
                end
                S_IDLE: begin
                    r_sw <= '0;
                    if (accept && (t_mode'(i_s_tdata[2:0]) == M_RESET
                        || t_mode'(i_s_tdata[2:0]) == M_CLRMIN)) begin
                        r_min <= '0;
                    end
                end
                S_UL_CHK: begin
                    if (do_ul && r_count != '0) begin
                        r_count <= r_count - CNT_W'(1);
                    end
                end
                S_INS_WR1: begin
                    if (r_count < CNT_W'(NODE_COUNT)) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                end
                S_POP_WR: begin
                    r_min   <= r_b;
                    r_count <= r_count - CNT_W'(1);
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode <= t_mode'(i_s_tdata[2:0]);
            r_node <= NODE_W'(i_s_tdata[12:3]);
            r_bw   <= BKT_W'(i_s_tdata[20:13]);
            r_nw   <= BKT_W'(i_s_tdata[28:21]);
            r_sv   <= i_s_tdata[30:29];
            r_pop  <= '0;
            r_nst  <= VS_NOT_VISITED;
            r_err  <= (t_mode'(i_s_tdata[2:0]) == M_POP) && (r_count == '0);
            r_b    <= r_min;
        end
        unique case (r_st)
            S_UL_CHK: r_nst <= t_vstate'(vst_rdata);
            S_INS_WR1: r_nst <= ins_state;
            S_SET: r_nst <= (r_mode == M_SET) ? t_vstate'(r_sv) : VS_REMOVED;
            S_POP_CHK: begin
                if (found) begin
                    r_h <= NODE_W'(head_rdata);
                end else if (r_b == BKT_W'(BUCKET_COUNT - 1)) begin
                    r_err <= 1'b1;
                end else begin
                    r_b <= r_b + BKT_W'(1);
                end
            end
            S_POP_WR: begin
                r_pop <= r_h;
                r_nst <= t_vstate'(vst_rdata);
            end
            default: begin
            end
        endcase
        if (load) begin
            r_o_pop   <= r_pop;
            r_o_nst   <= r_nst;
            r_o_count <= r_count;
            r_o_err   <= r_err;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {7'b0, r_o_err, (r_o_count == '0), r_o_count, r_o_nst, r_o_pop};
endmodule
